FILE: rtl/core/csov_pkg.sv
// ============================================================================
// Cursor sprite overlay package
// Shared constants, register indexes and the pipeline sideband type.
// ============================================================================
package csov_pkg;

  // Screen coordinates at or above this side length pass the background through.
  localparam int MAX_SCREEN_SIDE = 4096;

  // Width of a raw sprite offset before it wraps into the store.
  // The largest offset is 63 * 127 * 127 + 126 * 127 + 126, below 2**20.
  localparam int RAW_W = 20;

  // Configuration register file widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINTER_X     = 3'd0,
    CFG_POINTER_Y     = 3'd1,
    CFG_HOTSPOT_X     = 3'd2,
    CFG_HOTSPOT_Y     = 3'd3,
    CFG_SPRITE_WIDTH  = 3'd4,
    CFG_SPRITE_HEIGHT = 3'd5,
    CFG_FRAME_SELECT  = 3'd6,
    CFG_CURSOR_ENABLE = 3'd7
  } cfg_reg_t;

  // Sideband that travels with each request through the pipeline.
  typedef struct packed {
    logic       valid;
    logic       is_load;
    logic       hit;
    logic [7:0] background;
    logic [7:0] load_byte;
  } side_t;

endpackage

FILE: rtl/core/cursor_sprite_overlay_core.sv
// ============================================================================
// Cursor sprite overlay core
// Lays an indexed-color cursor sprite over a stream of screen pixels and
// loads the sprite store through the same request stream.
// ============================================================================
// The core accepts one request per clock unless stalled and returns one
// result per pixel request, none for a load request. The wrap of the
// sprite offset into the store is a chain of conditional subtractions,
// four per stage, over MOD_STAGES = ceil((21 - clog2(SPRITE_BYTES)) / 4)
// stages, and sets the pipeline depth. Loads and reads go through the
// single store port in the memory stage in request order, so a pixel
// always sees every load that was accepted before it.
// When the result is stalled the whole pipeline holds, and in_stall follows.
// Configuration writes are expected only while the pipeline is empty.
module cursor_sprite_overlay_core
  import csov_pkg::*;
#(
  parameter int SPRITE_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [11:0]           in_load_address,
  input  logic [7:0]            in_load_byte,
  input  logic [11:0]           in_screen_x,
  input  logic [11:0]           in_screen_y,
  input  logic [7:0]            in_background,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_pixel_out,
  output logic                  out_cursor_drawn
);

  localparam int AW         = $clog2(SPRITE_BYTES);
  localparam int MOD_STEPS  = RAW_W - AW + 1;
  localparam int SPS        = 4;
  localparam int MOD_STAGES = (MOD_STEPS + SPS - 1) / SPS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [11:0] pointer_x_r, pointer_y_r;
  logic [5:0]  hotspot_x_r, hotspot_y_r;
  logic [6:0]  sprite_width_r, sprite_height_r;
  logic [5:0]  frame_select_r;
  logic        cursor_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pointer_x_r     <= '0;
      pointer_y_r     <= '0;
      hotspot_x_r     <= '0;
      hotspot_y_r     <= '0;
      sprite_width_r  <= 7'd32;
      sprite_height_r <= 7'd32;
      frame_select_r  <= '0;
      cursor_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_POINTER_X:     pointer_x_r     <= cfg_wdata[11:0];
        CFG_POINTER_Y:     pointer_y_r     <= cfg_wdata[11:0];
        CFG_HOTSPOT_X:     hotspot_x_r     <= cfg_wdata[5:0];
        CFG_HOTSPOT_Y:     hotspot_y_r     <= cfg_wdata[5:0];
        CFG_SPRITE_WIDTH:  sprite_width_r  <= cfg_wdata[6:0];
        CFG_SPRITE_HEIGHT: sprite_height_r <= cfg_wdata[6:0];
        CFG_FRAME_SELECT:  frame_select_r  <= cfg_wdata[5:0];
        CFG_CURSOR_ENABLE: cursor_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves unless a finished result is stalled.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // Stage 1: sprite-relative coordinates and on-screen check.
  // --------------------------------------------------------------------------
  side_t       s1_side_r, s1_side_nxt;
  logic [13:0] s1_rx_r, s1_ry_r, s1_rx_nxt, s1_ry_nxt;
  logic        s1_onscreen_r, s1_onscreen_nxt;
  logic [11:0] s1_load_addr_r;

  always_comb begin
    s1_side_nxt.valid      = in_valid;
    s1_side_nxt.is_load    = !in_action;
    s1_side_nxt.hit        = 1'b0;
    s1_side_nxt.background = in_background;
    s1_side_nxt.load_byte  = in_load_byte;
    s1_rx_nxt = {2'b00, in_screen_x} - {2'b00, pointer_x_r} + {8'd0, hotspot_x_r};
    s1_ry_nxt = {2'b00, in_screen_y} - {2'b00, pointer_y_r} + {8'd0, hotspot_y_r};
    s1_onscreen_nxt = (32'(in_screen_x) < MAX_SCREEN_SIDE) &&
                      (32'(in_screen_y) < MAX_SCREEN_SIDE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.valid <= 1'b0;
    end else if (adv) begin
      s1_side_r <= s1_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rx_r        <= s1_rx_nxt;
      s1_ry_r        <= s1_ry_nxt;
      s1_onscreen_r  <= s1_onscreen_nxt;
      s1_load_addr_r <= in_load_address;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: window test and the first pair of products.
  // --------------------------------------------------------------------------
  side_t       s2_side_r, s2_side_nxt;
  logic [12:0] s2_fw_r, s2_fw_nxt;
  logic [13:0] s2_ryw_r, s2_ryw_nxt;
  logic [6:0]  s2_rx_r;
  logic [11:0] s2_load_addr_r;
  logic        win_x, win_y;

  always_comb begin
    win_x = !s1_rx_r[13] && (s1_rx_r[12:0] < {6'd0, sprite_width_r});
    win_y = !s1_ry_r[13] && (s1_ry_r[12:0] < {6'd0, sprite_height_r});
    s2_side_nxt     = s1_side_r;
    s2_side_nxt.hit = !s1_side_r.is_load && cursor_enable_r && s1_onscreen_r &&
                      win_x && win_y;
    s2_fw_nxt  = 13'(frame_select_r) * 13'(sprite_width_r);
    s2_ryw_nxt = 14'(s1_ry_r[6:0]) * 14'(sprite_width_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.valid <= 1'b0;
    end else if (adv) begin
      s2_side_r <= s2_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_fw_r        <= s2_fw_nxt;
      s2_ryw_r       <= s2_ryw_nxt;
      s2_rx_r        <= s1_rx_r[6:0];
      s2_load_addr_r <= s1_load_addr_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: frame base and offset inside the frame.
  // --------------------------------------------------------------------------
  side_t       s3_side_r;
  logic [RAW_W-1:0] s3_fwh_r, s3_fwh_nxt;
  logic [13:0] s3_off_r, s3_off_nxt;
  logic [11:0] s3_load_addr_r;

  always_comb begin
    s3_fwh_nxt = RAW_W'(s2_fw_r) * RAW_W'(sprite_height_r);
    s3_off_nxt = s2_ryw_r + 14'(s2_rx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r.valid <= 1'b0;
    end else if (adv) begin
      s3_side_r <= s2_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fwh_r       <= s3_fwh_nxt;
      s3_off_r       <= s3_off_nxt;
      s3_load_addr_r <= s2_load_addr_r;
    end
  end

  // --------------------------------------------------------------------------
  // Address wrap: raw address, then conditional subtraction of the store
  // size shifted left, four steps per stage, from the largest shift down.
  // --------------------------------------------------------------------------
  side_t            mod_side_r [MOD_STAGES+1];
  logic [RAW_W-1:0] mod_x_r    [MOD_STAGES+1];
  logic [RAW_W-1:0] mod_x_nxt  [MOD_STAGES+1];

  assign mod_x_nxt[0] = s3_side_r.is_load ? RAW_W'(s3_load_addr_r)
                                          : s3_fwh_r + RAW_W'(s3_off_r);

  for (genvar m = 0; m < MOD_STAGES; m++) begin : g_mod
    always_comb begin
      logic [RAW_W:0] x;
      logic [RAW_W:0] sub;
      x   = {1'b0, mod_x_r[m]};
      sub = '0;
      for (int j = 0; j < SPS; j++) begin
        if (MOD_STEPS - 1 - (m * SPS + j) >= 0) begin
          sub = (RAW_W + 1)'(SPRITE_BYTES) << (MOD_STEPS - 1 - (m * SPS + j));
          if (x >= sub) begin
            x = x - sub;
          end
        end
      end
      mod_x_nxt[m+1] = x[RAW_W-1:0];
    end
  end

  for (genvar m = 0; m <= MOD_STAGES; m++) begin : g_mod_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mod_side_r[m].valid <= 1'b0;
      end else if (adv) begin
        mod_side_r[m] <= (m == 0) ? s3_side_r : mod_side_r[(m == 0) ? 0 : m - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mod_x_r[m] <= mod_x_nxt[m];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Memory stage: a load writes the store (and the key at address zero),
  // a pixel reads it and keeps the key that applies to it.
  // --------------------------------------------------------------------------
  logic [7:0]    sprite_mem [SPRITE_BYTES];
  logic [AW-1:0] mem_addr;
  logic          mem_wr;
  side_t         mem_side_r;
  logic [7:0]    mem_rdata_r;
  logic [7:0]    mem_key_r;
  logic [7:0]    colour_key_r;

  assign mem_addr = mod_x_r[MOD_STAGES][AW-1:0];
  assign mem_wr   = adv && mod_side_r[MOD_STAGES].valid && mod_side_r[MOD_STAGES].is_load;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      sprite_mem[mem_addr] <= mod_side_r[MOD_STAGES].load_byte;
    end
    if (adv) begin
      mem_rdata_r <= sprite_mem[mem_addr];
      mem_key_r   <= colour_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_key_r <= '0;
    end else if (mem_wr && (mem_addr == '0)) begin
      colour_key_r <= mod_side_r[MOD_STAGES].load_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_side_r.valid <= 1'b0;
    end else if (adv) begin
      mem_side_r <= mod_side_r[MOD_STAGES];
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: the sprite byte wins on a hit unless it matches the key.
  // --------------------------------------------------------------------------
  logic       out_valid_nxt;
  logic       out_drawn_nxt;
  logic [7:0] out_pixel_nxt;
  logic       out_drawn_r;
  logic [7:0] out_pixel_r;

  always_comb begin
    out_valid_nxt = mem_side_r.valid && !mem_side_r.is_load;
    out_drawn_nxt = mem_side_r.hit && (mem_rdata_r != mem_key_r);
    out_pixel_nxt = out_drawn_nxt ? mem_rdata_r : mem_side_r.background;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_drawn_r <= out_drawn_nxt;
      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pixel_r;
  assign out_cursor_drawn = out_drawn_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // A stalled result freezes the memory stage behind it.
  a_stall_holds_mem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(mem_side_r))
    else $error("memory stage moved while the result was stalled");

  // A load request never produces a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mem_side_r.valid && mem_side_r.is_load) |=> !out_valid_r)
    else $error("load request produced a result");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Cursor sprite overlay core testbench
// Streams sprite loads and screen pixel requests into the core under
// randomized sender gaps and receiver stalls. A local model of the sprite
// store, the color key and the cursor window predicts every overlay result,
// and each result from the core is checked field by field in order.
// ============================================================================
module tb_top;
  import csov_pkg::*;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_PIXEL    = 1'b1;
  localparam int   STORE_DEPTH  = 4096;
  localparam int   DRAIN_CYCLES = 16;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   LIMIT_CYCLES = 200000;
  localparam int   PHASE_REQS   = 40;
  localparam int   MAX_REPORTS  = 50;

  typedef struct {
    logic        action;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [11:0] screen_x;
    logic [11:0] screen_y;
    logic [7:0]  background;
  } overlay_req_t;

  typedef struct {
    logic [7:0] pixel;
    logic       drawn;
  } overlay_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = ACT_LOAD;
  logic [11:0]           in_load_address = '0;
  logic [7:0]            in_load_byte = '0;
  logic [11:0]           in_screen_x = '0;
  logic [11:0]           in_screen_y = '0;
  logic [7:0]            in_background = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_pixel_out;
  logic                  out_cursor_drawn;

  // Shadow copy of the configuration registers.
  logic [11:0] ptr_x = 12'd0;
  logic [11:0] ptr_y = 12'd0;
  logic [5:0]  hot_x = 6'd0;
  logic [5:0]  hot_y = 6'd0;
  logic [6:0]  spr_w = 7'd32;
  logic [6:0]  spr_h = 7'd32;
  logic [5:0]  frame_sel = 6'd0;
  logic        cur_en = 1'b0;

  // Predicted sprite store and color key, updated as requests are accepted.
  logic [7:0] sprite_mem [STORE_DEPTH];
  logic [7:0] color_key = 8'd0;

  // Stimulus side view of which entries hold data and of the key value.
  bit         loaded [STORE_DEPTH];
  logic [7:0] stim_key = 8'd0;

  overlay_req_t pending_reqs [$];
  overlay_res_t expected_pixels [$];
  overlay_req_t bus_req;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_arm = 1'b0;
  int hold_count = 0;
  int errors = 0;
  int cycle_count = 0;

  cursor_sprite_overlay_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_load_address (in_load_address),
    .in_load_byte    (in_load_byte),
    .in_screen_x     (in_screen_x),
    .in_screen_y     (in_screen_y),
    .in_background   (in_background),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_cursor_drawn(out_cursor_drawn)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Finds the store entry a screen pixel maps to, if it lies in the window.
  function automatic bit window_lookup(input logic [11:0] sx, input logic [11:0] sy,
                                       output logic [11:0] addr);
    int rx;
    int ry;
    int offset;
    rx = int'(sx) - int'(ptr_x) + int'(hot_x);
    ry = int'(sy) - int'(ptr_y) + int'(hot_y);
    offset = int'(frame_sel) * int'(spr_w) * int'(spr_h) + ry * int'(spr_w) + rx;
    addr = offset[11:0];
    return cur_en && rx >= 0 && ry >= 0 && rx < int'(spr_w) && ry < int'(spr_h);
  endfunction

  // Applies one accepted request to the model and queues a pixel's overlay result.
  task automatic predict_overlay(input overlay_req_t req);
    logic [11:0]  addr;
    overlay_res_t res;
    if (req.action == ACT_LOAD) begin
      sprite_mem[req.load_address] = req.load_byte;
      if (req.load_address == 12'd0) color_key = req.load_byte;
    end else begin
      res.pixel = req.background;
      res.drawn = 1'b0;
      if (window_lookup(req.screen_x, req.screen_y, addr) &&
          sprite_mem[addr] != color_key) begin
        res.pixel = sprite_mem[addr];
        res.drawn = 1'b1;
      end
      expected_pixels.push_back(res);
    end
  endtask

  // Writes one configuration register while the core is idle.
  task automatic set_reg(input cfg_reg_t idx, input logic [11:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_POINTER_X:     ptr_x = value;
      CFG_POINTER_Y:     ptr_y = value;
      CFG_HOTSPOT_X:     hot_x = value[5:0];
      CFG_HOTSPOT_Y:     hot_y = value[5:0];
      CFG_SPRITE_WIDTH:  spr_w = value[6:0];
      CFG_SPRITE_HEIGHT: spr_h = value[6:0];
      CFG_FRAME_SELECT:  frame_sel = value[5:0];
      CFG_CURSOR_ENABLE: cur_en = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A sprite byte that is often the current key, so transparency shows up.
  function automatic logic [7:0] pick_byte();
    return ($urandom_range(0, 3) == 0) ? stim_key : 8'($urandom);
  endfunction

  // Picks an end of the range or a value in between.
  function automatic logic [11:0] pick_edge(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0:       return 12'(lo);
      1:       return 12'(hi);
      default: return 12'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [11:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return 12'd64;
      1:       return 12'd127;
      2:       return 12'd1;
      default: return 12'($urandom_range(2, 16));
    endcase
  endfunction

  task automatic push_load(input logic [11:0] addr, input logic [7:0] data);
    overlay_req_t req;
    req.action       = ACT_LOAD;
    req.load_address = addr;
    req.load_byte    = data;
    req.screen_x     = 12'($urandom);
    req.screen_y     = 12'($urandom);
    req.background   = 8'($urandom);
    loaded[addr] = 1'b1;
    if (addr == 12'd0) stim_key = data;
    pending_reqs.push_back(req);
  endtask

  // A pixel request; an unloaded entry under it gets a load first.
  task automatic push_pixel(input logic [11:0] sx, input logic [11:0] sy,
                            input logic [7:0] bg);
    overlay_req_t req;
    logic [11:0]  addr;
    if (window_lookup(sx, sy, addr) && !loaded[addr]) push_load(addr, pick_byte());
    req.action       = ACT_PIXEL;
    req.load_address = 12'($urandom);
    req.load_byte    = 8'($urandom);
    req.screen_x     = sx;
    req.screen_y     = sy;
    req.background   = bg;
    pending_reqs.push_back(req);
  endtask

  // Waits until every request is through and the pipeline has emptied.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random mix: mostly pixels around the cursor window, some loads and strays.
  task automatic run_phase(input int count);
    int sel;
    int base_x;
    int base_y;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      base_x = int'(ptr_x) - int'(hot_x) - 2;
      base_y = int'(ptr_y) - int'(hot_y) - 2;
      if (sel < 20) begin
        push_load(($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom), pick_byte());
      end else if (sel < 32) begin
        push_pixel(12'($urandom), 12'($urandom), 8'($urandom));
      end else begin
        push_pixel(12'(base_x + $urandom_range(0, int'(spr_w) + 3)),
                   12'(base_y + $urandom_range(0, int'(spr_h) + 3)), 8'($urandom));
      end
    end
  endtask

  // Request driver: feeds queued requests and predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_overlay(bus_req);
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          bus_req = pending_reqs.pop_front();
          in_valid        <= 1'b1;
          in_action       <= bus_req.action;
          in_load_address <= bus_req.load_address;
          in_load_byte    <= bus_req.load_byte;
          in_screen_x     <= bus_req.screen_x;
          in_screen_y     <= bus_req.screen_y;
          in_background   <= bus_req.background;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result and drives the receiver stall.
  always @(posedge clk) begin
    overlay_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual pixel %0h drawn %0b",
                   $time, out_pixel_out, out_cursor_drawn);
      end else begin
        exp_res = expected_pixels.pop_front();
        if (out_pixel_out !== exp_res.pixel) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: pixel_out mismatch, expected %0h actual %0h",
                     $time, exp_res.pixel, out_pixel_out);
        end
        if (out_cursor_drawn !== exp_res.drawn) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: cursor_drawn mismatch, expected %0b actual %0b",
                     $time, exp_res.drawn, out_cursor_drawn);
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_arm && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count++;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("cursor_sprite_overlay_core test failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Cursor disabled after reset: everything passes through.
    @(negedge clk);
    push_load(12'd0, 8'h3C);
    push_load(12'hFFF, 8'h3C);
    push_load(12'd1, 8'hC3);
    push_pixel(12'd0, 12'd0, 8'h00);
    push_pixel(12'hFFF, 12'hFFF, 8'hFF);
    wait_idle();

    // Window at the far screen corner, largest hotspot and last frame.
    set_reg(CFG_CURSOR_ENABLE, 12'd1);
    set_reg(CFG_POINTER_X, 12'hFFF);
    set_reg(CFG_POINTER_Y, 12'hFFF);
    set_reg(CFG_HOTSPOT_X, 12'd63);
    set_reg(CFG_HOTSPOT_Y, 12'd63);
    set_reg(CFG_SPRITE_WIDTH, 12'd64);
    set_reg(CFG_SPRITE_HEIGHT, 12'd64);
    set_reg(CFG_FRAME_SELECT, 12'd63);
    @(negedge clk);
    push_pixel(12'd4032, 12'd4032, 8'h11);
    push_pixel(12'hFFF, 12'hFFF, 8'h22);
    push_load(12'hFFF, 8'hA5);
    push_pixel(12'hFFF, 12'hFFF, 8'h22);
    push_pixel(12'd4031, 12'd4032, 8'h33);
    push_pixel(12'd4032, 12'd4031, 8'h44);
    wait_idle();

    // Zero width leaves an empty window.
    set_reg(CFG_SPRITE_WIDTH, 12'd0);
    @(negedge clk);
    push_pixel(12'd4032, 12'd4032, 8'h55);
    wait_idle();

    // Oversize frame; the read offset wraps around the store.
    set_reg(CFG_POINTER_X, 12'd0);
    set_reg(CFG_POINTER_Y, 12'd0);
    set_reg(CFG_HOTSPOT_X, 12'd0);
    set_reg(CFG_HOTSPOT_Y, 12'd0);
    set_reg(CFG_SPRITE_WIDTH, 12'd127);
    set_reg(CFG_SPRITE_HEIGHT, 12'd127);
    @(negedge clk);
    push_pixel(12'd126, 12'd126, 8'h66);
    push_pixel(12'd0, 12'd0, 8'h77);
    push_pixel(12'd127, 12'd0, 8'h88);
    wait_idle();

    // Zero height.
    set_reg(CFG_SPRITE_HEIGHT, 12'd0);
    @(negedge clk);
    push_pixel(12'd0, 12'd0, 8'h99);
    wait_idle();

    // Random phases, each with its own settings and flow pattern.
    for (int p = 0; p < 10; p++) begin
      set_reg(CFG_POINTER_X, pick_edge(0, 4095));
      set_reg(CFG_POINTER_Y, pick_edge(0, 4095));
      set_reg(CFG_HOTSPOT_X, pick_edge(0, 63));
      set_reg(CFG_HOTSPOT_Y, pick_edge(0, 63));
      set_reg(CFG_SPRITE_WIDTH, pick_size());
      set_reg(CFG_SPRITE_HEIGHT, pick_size());
      set_reg(CFG_FRAME_SELECT, pick_edge(0, 63));
      set_reg(CFG_CURSOR_ENABLE, ($urandom_range(0, 9) != 0) ? 12'd1 : 12'd0);
      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      // One long receiver hold while the sender keeps the core full.
      if (p == 4) hold_arm = 1'b1;
      run_phase(PHASE_REQS);
      wait_idle();
    end

    if (errors == 0) begin
      $display("cursor_sprite_overlay_core test passed");
    end else begin
      $display("cursor_sprite_overlay_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/csov_pkg.sv
rtl/core/cursor_sprite_overlay_core.sv
bench/tb_top.sv
